[rtl/dxt1_pkg.sv]
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared types and constants of the 4x4 colour block encoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

	// Colour kept at 5:6:5 precision, packed red 15..11, green 10..5, blue 4..0
	localparam int unsigned C565_W = 16;
	localparam int unsigned PIX_W  = 24;
	localparam int unsigned ERR_W  = 26;
	localparam int unsigned IDX_W  = 32;

	// Reciprocals for exact floor division of values below 2**20
	localparam logic [22:0] RECIP3 = 23'd1398102; // ceil(2**22 / 3)
	localparam logic [22:0] RECIP9 = 23'd1864136; // ceil(2**24 / 9)

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [15:0] first_endpoint;
		logic [15:0] second_endpoint;
		logic [31:0] index_bits;
	} block_t;

	// Pixel store write port of the scoring unit
	typedef struct packed {
		logic             en;
		logic [3:0]       addr;
		logic [PIX_W-1:0] data;
	} store_wr_t;

	// Request to score one endpoint pair
	typedef struct packed {
		logic              start;
		logic              n3;    // 1: three palette steps, 0: two
		logic [C565_W-1:0] ca;
		logic [C565_W-1:0] cb;
	} score_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ERR_W-1:0] err;
		logic [IDX_W-1:0]        idx;
	} score_rsp_t;

	// Expand one component of a 565 colour back to 8 bits (0 blue, 1 green, 2 red)
	function automatic logic [7:0] comp565(input logic [C565_W-1:0] c, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = {c[4:0], 3'b000};
			2'd1:    r = {c[10:5], 2'b00};
			default: r = {c[15:11], 3'b000};
		endcase
		return r;
	endfunction

	// One component of a full pixel (0 blue, 1 green, 2 red)
	function automatic logic [7:0] comp_pix(input logic [PIX_W-1:0] p, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = p[7:0];
			2'd1:    r = p[15:8];
			default: r = p[23:16];
		endcase
		return r;
	endfunction

endpackage

[rtl/dxt1_score.sv]
// ----------------------------------------------------------------------------
// dxt1_score
// Pixel store and pair scoring unit built around one shared multiplier.
// ----------------------------------------------------------------------------
module dxt1_score import dxt1_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_wr_t  wr,
	input  score_req_t req,
	output score_rsp_t rsp
);

	typedef enum logic [1:0] {S_IDLE, S_DD, S_LOAD, S_PX} state_t;

	state_t                  state_q;
	logic [3:0]              st_q;
	logic [3:0]              p_q;
	logic                    n3_q;
	logic [C565_W-1:0]       ca_q;
	logic [C565_W-1:0]       cb_q;
	logic [PIX_W-1:0]        pix_q;
	logic [17:0]             dd_q;
	logic [17:0]             vv_q;
	logic signed [18:0]      vd_q;
	logic [1:0]              ch_q;
	logic signed [21:0]      t2_q;
	logic [19:0]             t3_q;
	logic signed [ERR_W-1:0] err_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    done_q;

	logic [PIX_W-1:0] store_q [16];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr] <= wr.data;
		end
	end

	// Per component differences
	logic signed [8:0] d_c [3];
	logic signed [8:0] v_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k] = $signed({1'b0, comp565(cb_q, 2'(k))}) - $signed({1'b0, comp565(ca_q, 2'(k))});
			v_c[k] = $signed({1'b0, comp_pix(pix_q, 2'(k))}) - $signed({1'b0, comp565(ca_q, 2'(k))});
		end
	end

	// Choice of palette step, clamped to 0..n
	logic signed [21:0] num;
	logic [19:0]        dd2;
	logic [19:0]        dd3;
	logic [1:0]         ch_c;
	always_comb begin
		num = (n3_q ? (22'(vd_q) * 22'sd3) : (22'(vd_q) * 22'sd2)) + $signed({4'b0, dd_q >> 1});
		dd2 = {1'b0, dd_q, 1'b0};
		dd3 = dd2 + {2'b0, dd_q};
		ch_c = 2'd0;
		if (dd_q != '0 && !num[21]) begin
			ch_c = 2'(num[20:0] >= {3'b0, dd_q}) + 2'(num[20:0] >= {1'b0, dd2})
				+ 2'(n3_q && (num[20:0] >= {1'b0, dd3}));
		end
	end

	logic [17:0] abs_vd;
	logic [19:0] x_div;
	logic [19:0] y_div;
	logic        ch_full;
	logic        mid3;
	assign abs_vd  = vd_q[18] ? 18'(-vd_q) : vd_q[17:0];
	assign x_div   = (ch_q == 2'd1) ? {1'b0, abs_vd, 1'b0} : {abs_vd, 2'b00};
	assign y_div   = (ch_q == 2'd1) ? {2'b0, dd_q} : {dd_q, 2'b00};
	assign ch_full = n3_q ? (ch_q == 2'd3) : (ch_q == 2'd2);
	assign mid3    = n3_q && ch_q != 2'd0 && ch_q != 2'd3;

	// Shared multiplier
	logic [1:0]         kidx;
	logic signed [22:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [45:0] prod;
	always_comb begin
		kidx  = (st_q < 4'd3) ? st_q[1:0] : 2'(st_q - 4'd3);
		mul_a = 23'(d_c[kidx]);
		mul_b = 23'(d_c[kidx]);
		if (state_q == S_PX) begin
			if (st_q < 4'd3) begin
				mul_a = 23'(v_c[kidx]);
				mul_b = 23'(v_c[kidx]);
			end else if (st_q < 4'd6) begin
				mul_a = 23'(v_c[kidx]);
			end else if (st_q == 4'd7) begin
				mul_a = $signed({3'b0, x_div});
				mul_b = $signed(RECIP3);
			end else begin
				mul_a = $signed({3'b0, y_div});
				mul_b = $signed(RECIP9);
			end
		end
		prod = mul_a * mul_b;
	end

	logic [1:0] code;
	always_comb begin
		if (ch_q == 2'd0) code = 2'd0;
		else if (ch_full) code = 2'd1;
		else code = ch_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= '0;
			p_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			// Pulse done on the last step of the last pixel
			done_q <= (state_q == S_PX) && (st_q > 4'd8) && (p_q == 4'd15);
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						n3_q    <= req.n3;
						ca_q    <= req.ca;
						cb_q    <= req.cb;
						dd_q    <= '0;
						err_q   <= '0;
						st_q    <= '0;
						p_q     <= '0;
						state_q <= S_DD;
					end
				end
				S_DD: begin
					dd_q <= dd_q + prod[17:0];
					if (st_q == 4'd2) begin
						state_q <= S_LOAD;
					end else begin
						st_q <= st_q + 4'd1;
					end
				end
				S_LOAD: begin
					pix_q   <= store_q[p_q];
					st_q    <= '0;
					state_q <= S_PX;
				end
				S_PX: begin
					st_q <= st_q + 4'd1;
					case (st_q)
						4'd0: vv_q <= prod[17:0];
						4'd1, 4'd2: vv_q <= vv_q + prod[17:0];
						4'd3: vd_q <= prod[18:0];
						4'd4, 4'd5: vd_q <= vd_q + prod[18:0];
						4'd6: ch_q <= ch_c;
						4'd7: begin
							if (ch_q == 2'd0) t2_q <= '0;
							else if (mid3) t2_q <= vd_q[18] ? -$signed({2'b0, prod[41:22]})
								: $signed({2'b0, prod[41:22]});
							else if (ch_full) t2_q <= 22'(vd_q) * 22'sd2;
							else t2_q <= 22'(vd_q);
						end
						4'd8: begin
							if (ch_q == 2'd0) t3_q <= '0;
							else if (mid3) t3_q <= prod[43:24];
							else if (ch_full) t3_q <= {2'b0, dd_q};
							else t3_q <= {4'b0, dd_q[17:2]};
						end
						default: begin
							err_q <= err_q + $signed({8'b0, vv_q}) - ERR_W'(t2_q)
								+ $signed({6'b0, t3_q});
							idx_q[{p_q, 1'b0} +: 2] <= code;
							if (p_q == 4'd15) begin
								state_q <= S_IDLE;
							end else begin
								p_q     <= p_q + 4'd1;
								state_q <= S_LOAD;
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.err  = err_q;
	assign rsp.idx  = idx_q;

endmodule

[rtl/dxt1_color_block_encoder.sv]
// ----------------------------------------------------------------------------
// dxt1_color_block_encoder
// BC1 colour block encoder with an exhaustive search over endpoint pairs drawn from the block's colours.
// ----------------------------------------------------------------------------
// Feed the sixteen pixels of a 4x4 block in raster order, one item per pixel.
// The input does not stall while the sixteen pixels are collected. After the
// sixteenth the input stalls while every pair of distinct 5:6:5 colours is
// scored in three- and four-colour mode, followed by one more pass over the
// winning pair to produce the indices. All scoring runs through one shared
// multiplier, so the stall grows with the number of distinct colours; a
// flat block skips the pair search and is scored only in the final pass.
// One result item leaves per block; the next block may start to load while it
// still waits to be taken.
module dxt1_color_block_encoder import dxt1_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_stall,
	input  pixel_t pixel,
	output logic   block_valid,
	input  logic   block_stall,
	output block_t block
);

	typedef enum logic [2:0] {
		S_COLLECT, S_START, S_LOAD, S_WAIT, S_FINAL, S_FWAIT, S_EMIT
	} state_t;

	state_t                  state_q;
	logic [3:0]              pix_cnt_q;
	logic [4:0]              cnt_q;
	logic [C565_W-1:0]       colors_q [16];
	logic [3:0]              i_q;
	logic [3:0]              j_q;
	logic                    n3_q;
	logic                    start_q;
	logic [C565_W-1:0]       ca_q;
	logic [C565_W-1:0]       cb_q;
	logic                    has_best_q;
	logic signed [ERR_W-1:0] best_err_q;
	logic [C565_W-1:0]       best_a_q;
	logic [C565_W-1:0]       best_b_q;
	logic                    best_n3_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    block_valid_q;
	block_t                  block_q;

	store_wr_t  wr;
	score_req_t req;
	score_rsp_t rsp;

	logic              accept;
	logic [C565_W-1:0] q565;
	logic              found;
	logic              emit;

	assign accept      = pixel_valid && !pixel_stall;
	assign pixel_stall = (state_q != S_COLLECT);
	assign q565        = {pixel.red[7:3], pixel.green[7:2], pixel.blue[7:3]};
	// Load the output register when it is free or being emptied this cycle
	assign emit        = (state_q == S_EMIT) && (!block_valid_q || !block_stall);

	// Look the cut colour up among those already seen in this block
	always_comb begin
		found = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (5'(k) < cnt_q && colors_q[k] == q565) found = 1'b1;
		end
	end

	assign wr.en   = accept;
	assign wr.addr = pix_cnt_q;
	assign wr.data = pixel;

	assign req.start = start_q;
	assign req.n3    = n3_q;
	assign req.ca    = ca_q;
	assign req.cb    = cb_q;

	dxt1_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.req    (req),
		.rsp    (rsp)
	);

	logic better;
	logic swap;
	assign better = !has_best_q || (rsp.err < best_err_q);
	// Three-colour mode wants first <= second, four-colour mode first > second
	assign swap   = (best_a_q > best_b_q) != best_n3_q;

	always_ff @(posedge clk) begin
		if (accept && !found && !cnt_q[4]) begin
			colors_q[cnt_q[3:0]] <= q565;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_COLLECT;
			pix_cnt_q     <= '0;
			cnt_q         <= '0;
			i_q           <= '0;
			j_q           <= '0;
			n3_q          <= 1'b0;
			start_q       <= 1'b0;
			has_best_q    <= 1'b0;
			block_valid_q <= 1'b0;
		end else begin
			// Pulse a scoring request for a new pair, the second mode or the final pass
			start_q <= (state_q == S_LOAD) || (state_q == S_FINAL)
				|| (state_q == S_WAIT && rsp.done && !n3_q);
			// Raise the result item when loaded, drop it once it is taken
			if (emit) begin
				block_valid_q <= 1'b1;
			end else if (block_valid_q && !block_stall) begin
				block_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_COLLECT: begin
					if (accept) begin
						if (!found && !cnt_q[4]) cnt_q <= cnt_q + 5'd1;
						pix_cnt_q <= pix_cnt_q + 4'd1;
						if (pix_cnt_q == 4'd15) state_q <= S_START;
					end
				end
				S_START: begin
					has_best_q <= 1'b0;
					i_q        <= 4'd0;
					j_q        <= 4'd1;
					n3_q       <= 1'b0;
					if (cnt_q <= 5'd1) begin
						// Single colour: both endpoints equal, four-colour mode
						best_a_q  <= colors_q[0];
						best_b_q  <= colors_q[0];
						best_n3_q <= 1'b1;
						state_q   <= S_FINAL;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					ca_q    <= colors_q[i_q];
					cb_q    <= colors_q[j_q];
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						if (better) begin
							has_best_q <= 1'b1;
							best_err_q <= rsp.err;
							best_a_q   <= ca_q;
							best_b_q   <= cb_q;
							best_n3_q  <= n3_q;
						end
						if (!n3_q) begin
							n3_q <= 1'b1;
						end else begin
							n3_q <= 1'b0;
							if ({1'b0, j_q} + 5'd1 < cnt_q) begin
								j_q     <= j_q + 4'd1;
								state_q <= S_LOAD;
							end else if ({1'b0, i_q} + 5'd2 < cnt_q) begin
								i_q     <= i_q + 4'd1;
								j_q     <= i_q + 4'd2;
								state_q <= S_LOAD;
							end else begin
								state_q <= S_FINAL;
							end
						end
					end
				end
				S_FINAL: begin
					ca_q    <= swap ? best_b_q : best_a_q;
					cb_q    <= swap ? best_a_q : best_b_q;
					n3_q    <= best_n3_q;
					cnt_q   <= '0;
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					if (rsp.done) begin
						idx_q   <= rsp.idx;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// Hold until the output register is free
					if (emit) begin
						block_q.first_endpoint  <= ca_q;
						block_q.second_endpoint <= cb_q;
						block_q.index_bits      <= idx_q;
						state_q                 <= S_COLLECT;
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	assign block_valid = block_valid_q;
	assign block       = block_q;

endmodule

[rtl/dxt1_checker.sv]
// ----------------------------------------------------------------------------
// dxt1_checker
// Port level checks of the colour block encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dxt1_checker import dxt1_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   block_valid,
	input logic   block_stall,
	input block_t block
);

	logic has_three;
	assign has_three = |(block.index_bits & (block.index_bits >> 1) & 32'h5555_5555);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && block_stall |=> block_valid)
		else $error("result item withdrawn while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && block_stall |=> $stable(block))
		else $error("stalled result item changed");

	a_flat_block: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && block.first_endpoint == block.second_endpoint
		|-> block.index_bits == 32'h0)
		else $error("equal endpoints with non-zero indices");

	a_three_colour: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && block.first_endpoint <= block.second_endpoint |-> !has_three)
		else $error("index 3 used in three-colour mode");

endmodule

bind dxt1_color_block_encoder dxt1_checker u_dxt1_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.block_valid (block_valid),
	.block_stall (block_stall),
	.block       (block)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 colour block encoder: pixels go in as items,
// a built-in block model predicts endpoints and indices, and results are checked.
// ----------------------------------------------------------------------------
module testbench;
	import dxt1_pkg::*;

	// Block model and store of expected blocks
	class block_scoreboard;
		logic [23:0] pix_mem [16];
		logic [23:0] colours [16];
		int          n_colours;
		int          pix_pos;
		block_t      pending [$];
		int          errors;

		function new();
			n_colours = 0;
			pix_pos   = 0;
			errors    = 0;
		endfunction

		function int chan(logic [23:0] c, int k);
			return int'(c[8*k +: 8]);
		endfunction

		function logic [15:0] pack565(logic [23:0] c);
			return {c[23:19], c[15:10], c[7:3]};
		endfunction

		// Error of a pair with n steps over the stored pixels, and its indices
		function int pair_error(int n, logic [23:0] ca, logic [23:0] cb,
				output logic [31:0] idx);
			int d [3];
			int dd, err, vv, vd, ch, v;
			dd  = 0;
			err = 0;
			idx = '0;
			for (int k = 0; k < 3; k++) begin
				d[k] = chan(cb, k) - chan(ca, k);
				dd += d[k] * d[k];
			end
			for (int p = 15; p >= 0; p--) begin
				vv = 0;
				vd = 0;
				ch = 0;
				for (int k = 0; k < 3; k++) begin
					v = chan(pix_mem[p], k) - chan(ca, k);
					vv += v * v;
					vd += v * d[k];
				end
				if (dd > 0) begin
					ch = (n * vd + (dd >>> 1)) / dd;
					if (ch < 0)
						ch = 0;
					else if (ch > n)
						ch = n;
				end
				err += vv - (2 * ch * vd) / n + (ch * ch * dd) / (n * n);
				idx = idx << 2;
				if (ch == n)
					idx = idx + 1;
				else if (ch > 0)
					idx = idx + ch + 1;
			end
			return err;
		endfunction

		// Take one accepted pixel; on the sixteenth, predict the block
		function void note_pixel(pixel_t px);
			logic [23:0] full, q, a, b, t;
			logic [15:0] ea, eb, t16;
			logic [31:0] idx;
			int          best, err, steps;
			bit          seen;
			block_t      res;
			full = px;
			q    = full & 24'hf8fcf8;
			pix_mem[pix_pos] = full;
			seen = 0;
			for (int i = 0; i < n_colours; i++)
				if (colours[i] == q)
					seen = 1;
			if (!seen && n_colours < 16) begin
				colours[n_colours] = q;
				n_colours++;
			end
			if (pix_pos != 15) begin
				pix_pos++;
				return;
			end
			pix_pos = 0;
			a     = colours[0];
			b     = colours[0];
			steps = 3;
			if (n_colours > 1) begin
				best = 32'h40000000;
				for (int i = 0; i + 1 < n_colours; i++)
					for (int j = i + 1; j < n_colours; j++) begin
						err = pair_error(2, colours[i], colours[j], idx);
						if (err < best) begin
							a = colours[i]; b = colours[j]; steps = 2; best = err;
						end
						err = pair_error(3, colours[i], colours[j], idx);
						if (err < best) begin
							a = colours[i]; b = colours[j]; steps = 3; best = err;
						end
					end
			end
			n_colours = 0;
			ea = pack565(a);
			eb = pack565(b);
			// four-colour mode wants first > second, three-colour the opposite
			if ((ea > eb) != (steps == 3)) begin
				t16 = ea; ea = eb; eb = t16;
				t   = a;  a  = b;  b  = t;
			end
			err = pair_error(steps, a, b, idx);
			res.first_endpoint  = ea;
			res.second_endpoint = eb;
			res.index_bits      = idx;
			pending.push_back(res);
		endfunction

		function void check_block(block_t got);
			block_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected block %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.first_endpoint !== want.first_endpoint) begin
				$display("%0t: first_endpoint expected %h actual %h", $time,
					want.first_endpoint, got.first_endpoint);
				errors++;
			end
			if (got.second_endpoint !== want.second_endpoint) begin
				$display("%0t: second_endpoint expected %h actual %h", $time,
					want.second_endpoint, got.second_endpoint);
				errors++;
			end
			if (got.index_bits !== want.index_bits) begin
				$display("%0t: index_bits expected %h actual %h", $time,
					want.index_bits, got.index_bits);
				errors++;
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   pixel_valid;
	logic   pixel_stall;
	pixel_t pixel;
	logic   block_valid;
	logic   block_stall;
	block_t block;

	block_scoreboard sb;

	// Idle rates in percent, changed per phase
	int send_idle;
	int recv_idle;
	bit hold_req;

	dxt1_color_block_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.block_valid(block_valid),
		.block_stall(block_stall),
		.block      (block)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stall, plus one long hold-off counted here so the
	// encoder fills up with a finished block and a loaded one behind it
	initial begin
		int hold_left;
		hold_left = 0;
		block_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 0;
				hold_left = 6000;
			end
			if (hold_left > 0) begin
				hold_left--;
				block_stall <= 1'b1;
			end else
				block_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Check every result item taken
	always @(posedge clk)
		if (arst_n && block_valid && !block_stall)
			sb.check_block(block);

	// Offer one pixel, idling first at the sender's rate; hold until taken
	task automatic send_pixel(logic [23:0] rgb);
		while ($urandom_range(99) < send_idle) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= rgb;
		do
			@(posedge clk);
		while (pixel_stall);
		sb.note_pixel(rgb);
	endtask

	// Random block: a palette of k cut colours, low bits left random
	task automatic send_block(int k);
		logic [23:0] pal [16];
		for (int i = 0; i < k; i++)
			pal[i] = 24'($urandom()) & 24'hf8fcf8;
		for (int p = 0; p < 16; p++)
			send_pixel(pal[$urandom_range(k - 1)] | (24'($urandom()) & 24'h070307));
	endtask

	initial begin
		logic [23:0] edge_px [16];
		int          k;
		sb          = new();
		send_idle   = 28;
		recv_idle   = 87;
		hold_req    = 0;
		arst_n      <= 1'b0;
		pixel_valid <= 1'b0;
		pixel       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of every channel, then a flat block
		edge_px = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
			24'h0000ff, 24'h070307, 24'hf8fcf8, 24'h000000,
			24'hffffff, 24'h808080, 24'h7f7f7f, 24'hff00ff,
			24'h00ffff, 24'hffff00, 24'h010101, 24'hfefefe};
		foreach (edge_px[p])
			send_pixel(edge_px[p]);
		for (int p = 0; p < 16; p++)
			send_pixel(24'h3c5a96 | (24'($urandom()) & 24'h070307));

		for (int blk = 0; blk < 86; blk++) begin
			if (blk == 28) begin
				send_idle = 87;
				recv_idle = 28;
			end else if (blk == 57) begin
				send_idle = 0;
				recv_idle = 0;
				hold_req  = 1;
			end
			// wide blocks are slow, so keep them few
			if (blk % 29 == 5)
				k = 16;
			else if (blk % 17 == 3)
				k = 1;
			else
				k = $urandom_range(2, 5);
			send_block(k);
		end
		pixel_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog well above the slowest correct run
	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/dxt1_pkg.sv
rtl/dxt1_score.sv
rtl/dxt1_color_block_encoder.sv
rtl/dxt1_checker.sv
bench/testbench.sv
